// File: rtl/mrc_pkg.sv
package mrc_pkg;

	localparam int CMD_IDX_W = 6;
	localparam int CMD_QTY_W = 7;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SLAVE     = 3'd1;
	localparam logic [2:0] ST_FUNCTION  = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_RANGE     = 3'd4;

	localparam logic [7:0] FUNC_READ_COILS = 8'h01;

	localparam logic [1:0] REG_SLAVE_ADDRESS = 2'd0;
	localparam logic [1:0] REG_COIL_BASE     = 2'd1;
	localparam logic [1:0] REG_ADDR_OFFSET   = 2'd2;
	localparam logic [1:0] REG_COIL_VALUES   = 2'd3;

	localparam logic [7:0]  RST_SLAVE_ADDRESS = 8'd1;
	localparam logic [15:0] RST_COIL_BASE     = 16'h1000;
	localparam logic [15:0] RST_ADDR_OFFSET   = 16'h0000;
	localparam logic [15:0] RST_COIL_VALUES   = 16'd39789;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	localparam int COIL_TABLE_W = 16;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} req_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       last;
		logic [2:0] status;
	} rsp_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [7:0]           slave;
		logic [CMD_IDX_W-1:0] idx;
		logic [CMD_QTY_W-1:0] qty;
	} cmd_t;

endpackage

// File: rtl/modbus_read_coils_responder.sv
// A status word passes the front stage registers, the command queue and the output
// register after the sixth request word is taken. A good answer gives 3 + n header and
// coil words for n coil bytes, each followed by a pass of the bit-serial CRC unit, then
// two CRC words. A request takes six input words, one per cycle unless full is high;
// the CRC unit sets the answer rate. Reset clears the request position, the command
// queue and the valid flag, and loads slave 1, coil base 0x1000, offset 0, values 0x9B6D.
module modbus_read_coils_responder import mrc_pkg::*; #(
	parameter int NUM_COILS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  req_t        req,
	output logic        empty,
	input  logic        pop,
	output rsp_t        rsp,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  slave_address_q;
	logic [15:0] coil_base_q;
	logic [15:0] addr_offset_q;
	logic [15:0] coil_values_q;

	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_empty;
	cmd_t cmd_in;
	cmd_t cmd_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= RST_SLAVE_ADDRESS;
			coil_base_q     <= RST_COIL_BASE;
			addr_offset_q   <= RST_ADDR_OFFSET;
			coil_values_q   <= RST_COIL_VALUES;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SLAVE_ADDRESS: slave_address_q <= cfg_data[7:0];
				REG_COIL_BASE:     coil_base_q     <= cfg_data;
				REG_ADDR_OFFSET:   addr_offset_q   <= cfg_data;
				REG_COIL_VALUES:   coil_values_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	mrc_front #(
		.NUM_COILS(NUM_COILS)
	) u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.req              (req),
		.slave_address    (slave_address_q),
		.coil_base_address(coil_base_q),
		.address_offset   (addr_offset_q),
		.cmd_push         (cmd_push),
		.cmd              (cmd_in),
		.cmd_full         (cmd_full)
	);

	mrc_cmd_fifo u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cmd_push),
		.wdata (cmd_in),
		.full  (cmd_full),
		.pop   (cmd_pop),
		.rdata (cmd_out),
		.empty (cmd_empty)
	);

	mrc_back #(
		.NUM_COILS(NUM_COILS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.coil_values(coil_values_q),
		.cmd        (cmd_out),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.empty      (empty),
		.pop        (pop),
		.rsp        (rsp)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd_push && cmd_full))
		else $error("Command pushed into a full queue.");

	a_status_word_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rsp.status != ST_OK) |-> (rsp.last && rsp.tx_byte == 8'd0))
		else $error("Status word is not a single final zero word.");

	a_full_needs_held_command: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (cmd_full && !cmd_empty))
		else $error("Input stalled while the command queue has room.");

endmodule

// File: rtl/mrc_front.sv
module mrc_front import mrc_pkg::*; #(
	parameter int NUM_COILS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  req_t        req,
	input  logic [7:0]  slave_address,
	input  logic [15:0] coil_base_address,
	input  logic [15:0] address_offset,
	output logic        cmd_push,
	output cmd_t        cmd,
	input  logic        cmd_full
);

	localparam logic [16:0] NUM_C = 17'(NUM_COILS);

	logic [2:0]  pos_q;
	logic [39:0] shift_q;
	logic        valid_s1;
	logic [7:0]  slave_s1;
	logic [7:0]  func_s1;
	logic [15:0] start_s1;
	logic [15:0] qty_s1;

	logic        accept;
	logic [2:0]  pos_eff;
	logic [15:0] addr;
	logic [15:0] idx16;
	logic [16:0] end17;

	assign full     = valid_s1 && cmd_full;
	assign accept   = push && !full;
	assign pos_eff  = req.frame_start ? 3'd0 : pos_q;
	assign cmd_push = valid_s1 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 3'd0;
			shift_q  <= 40'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (pos_eff < 3'd5) begin
					shift_q <= {(req.frame_start ? 32'd0 : shift_q[31:0]), req.rx_byte};
					pos_q   <= pos_eff + 3'd1;
				end else begin
					pos_q   <= 3'd0;
					shift_q <= 40'd0;
				end
			end
			if (accept && pos_eff == 3'd5) begin
				valid_s1 <= 1'b1;
			end else if (cmd_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_eff == 3'd5) begin
			slave_s1 <= shift_q[39:32];
			func_s1  <= shift_q[31:24];
			start_s1 <= shift_q[23:8];
			qty_s1   <= {shift_q[7:0], req.rx_byte};
		end
	end

	assign addr  = start_s1 + address_offset;
	assign idx16 = addr - coil_base_address;
	assign end17 = {1'b0, idx16} + {1'b0, qty_s1};

	always_comb begin
		cmd.slave = slave_s1;
		cmd.idx   = idx16[CMD_IDX_W-1:0];
		cmd.qty   = qty_s1[CMD_QTY_W-1:0];
		if (slave_s1 != slave_address) begin
			cmd.status = ST_SLAVE;
		end else if (func_s1 != FUNC_READ_COILS) begin
			cmd.status = ST_FUNCTION;
		end else if ({1'b0, idx16} >= NUM_C) begin
			cmd.status = ST_NOT_FOUND;
		end else if (qty_s1 == 16'd0 || end17 > NUM_C) begin
			cmd.status = ST_RANGE;
		end else begin
			cmd.status = ST_OK;
		end
	end

endmodule

// File: rtl/mrc_cmd_fifo.sv
module mrc_cmd_fifo import mrc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t wdata,
	output logic full,
	input  logic pop,
	output cmd_t rdata,
	output logic empty
);

	cmd_t       mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign full    = count_q == 2'd2;
	assign empty   = count_q == 2'd0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

// File: rtl/mrc_back.sv
module mrc_back import mrc_pkg::*; #(
	parameter int NUM_COILS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] coil_values,
	input  cmd_t        cmd,
	input  logic        cmd_empty,
	output logic        cmd_pop,
	output logic        empty,
	input  logic        pop,
	output rsp_t        rsp
);

	localparam int DATA_W = ((NUM_COILS + 7) / 8) * 8;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_BYTE = 2'd1;
	localparam logic [1:0] S_CRC  = 2'd2;

	logic [1:0]        state_q;
	logic [3:0]        cnt_q;
	logic [2:0]        bit_q;
	logic [15:0]       crc_q;
	logic [3:0]        nbytes_q;
	logic [7:0]        slave_q;
	logic [DATA_W-1:0] data_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic              out_free;
	logic [DATA_W-1:0] coil_ext;
	logic [DATA_W-1:0] coil_sel;
	logic [7:0]        qty_sum;
	logic [3:0]        body_len;
	logic [7:0]        cur_byte;

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign rsp      = out_q;
	assign cmd_pop  = state_q == S_IDLE && !cmd_empty && out_free;
	assign qty_sum  = {1'b0, cmd.qty} + 8'd7;
	assign body_len = 4'd3 + nbytes_q;

	always_comb begin
		for (int i = 0; i < DATA_W; i++) begin
			coil_ext[i] = (i < COIL_TABLE_W) ? coil_values[i % COIL_TABLE_W] : 1'b0;
		end
		coil_sel = coil_ext >> cmd.idx;
		for (int i = 0; i < DATA_W; i++) begin
			if (8'(i) >= {1'b0, cmd.qty}) begin
				coil_sel[i] = 1'b0;
			end
		end
	end

	always_comb begin
		if (cnt_q == 4'd0) begin
			cur_byte = slave_q;
		end else if (cnt_q == 4'd1) begin
			cur_byte = FUNC_READ_COILS;
		end else if (cnt_q == 4'd2) begin
			cur_byte = {4'd0, nbytes_q};
		end else if (cnt_q < body_len) begin
			cur_byte = data_q[7:0];
		end else if (cnt_q == body_len) begin
			cur_byte = crc_q[7:0];
		end else begin
			cur_byte = crc_q[15:8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			cnt_q       <= 4'd0;
			bit_q       <= 3'd0;
		end else begin
			if (out_valid_q && pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_pop) begin
						cnt_q <= 4'd0;
						if (cmd.status != ST_OK) begin
							out_valid_q <= 1'b1;
						end else begin
							state_q <= S_BYTE;
						end
					end
				end
				S_BYTE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (cnt_q < body_len) begin
							bit_q   <= 3'd0;
							state_q <= S_CRC;
						end else if (cnt_q == body_len) begin
							cnt_q <= cnt_q + 4'd1;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_CRC: begin
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						cnt_q   <= cnt_q + 4'd1;
						state_q <= S_BYTE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_pop) begin
					out_q    <= '{tx_byte: 8'd0, last: 1'b1, status: cmd.status};
					slave_q  <= cmd.slave;
					nbytes_q <= qty_sum[6:3];
					data_q   <= coil_sel;
					crc_q    <= CRC_INIT;
				end
			end
			S_BYTE: begin
				if (out_free) begin
					out_q <= '{tx_byte: cur_byte, last: cnt_q > body_len, status: ST_OK};
					if (cnt_q < body_len) begin
						crc_q <= crc_q ^ {8'd0, cur_byte};
					end
					if (cnt_q >= 4'd3 && cnt_q < body_len) begin
						data_q <= data_q >> 8;
					end
				end
			end
			S_CRC: begin
				crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
			end
			default: begin
			end
		endcase
	end

endmodule
